/* design/bst_pkg.sv */
// Shared constants, codes and types of the brightest spot table.
package bst_pkg;

   localparam int TABLE_SLOTS    = 64;
   localparam int COORD_BITS     = 12;
   localparam int SLOT_BITS      = $clog2(TABLE_SLOTS);
   localparam int COUNT_BITS     = $clog2(TABLE_SLOTS + 1);
   localparam int ACTIVE_BITS    = 7;
   localparam int NEAR_BITS      = 12;
   localparam int THRESH_BITS    = 23;
   localparam int STRENGTH_BITS  = 23;
   localparam int PLANE_BITS     = 10;
   localparam int UNIT_BITS      = (COORD_BITS > NEAR_BITS) ? COORD_BITS : NEAR_BITS;
   localparam int D2_BITS        = 2 * UNIT_BITS + 1;
   localparam int SCALED_BITS    = NEAR_BITS + 3;
   localparam int DIV6_MUL       = 10923;
   localparam int DIV6_MUL_BITS  = 14;
   localparam int DIV6_SHIFT     = 16;
   localparam int PROD_BITS      = SCALED_BITS + DIV6_MUL_BITS;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 23;

   typedef enum logic [1:0] {
      OP_OFFER = 2'd0,
      OP_DUMP  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ACT_IGNORED  = 3'd0,
      ACT_REPLACED = 3'd1,
      ACT_FILLED   = 3'd2,
      ACT_EVICTED  = 3'd3,
      ACT_REJECTED = 3'd4,
      ACT_DUMP     = 3'd5,
      ACT_CLEARED  = 3'd6
   } action_type;

   typedef enum logic [1:0] {
      CSR_ACTIVE_SLOTS  = 2'd0,
      CSR_NEAR_DISTANCE = 2'd1,
      CSR_THRESHOLD     = 2'd2
   } csr_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ONE,
      ST_PREP0,
      ST_PREP1,
      ST_PREP2,
      ST_PREP3,
      ST_SCAN,
      ST_DRAIN,
      ST_DECIDE,
      ST_CLR,
      ST_DUMP_RD,
      ST_DUMP_EMIT
   } state_type;

   typedef struct packed {
      logic [COORD_BITS-1:0]    x;
      logic [COORD_BITS-1:0]    y;
      logic [PLANE_BITS-1:0]    plane;
      logic [STRENGTH_BITS-1:0] strength;
   } entry_type;

endpackage

/* design/bst_dist.sv */
// Shared squared distance unit: (ax - bx)^2 + (ay - by)^2, registered.
module bst_dist (
   input  logic                          clock,
   input  logic [bst_pkg::UNIT_BITS-1:0] a_x,
   input  logic [bst_pkg::UNIT_BITS-1:0] b_x,
   input  logic [bst_pkg::UNIT_BITS-1:0] a_y,
   input  logic [bst_pkg::UNIT_BITS-1:0] b_y,
   output logic [bst_pkg::D2_BITS-1:0]   dist_sq
);

   logic signed [bst_pkg::UNIT_BITS:0]       dx;
   logic signed [bst_pkg::UNIT_BITS:0]       dy;
   logic signed [2*bst_pkg::UNIT_BITS+1:0]   px;
   logic signed [2*bst_pkg::UNIT_BITS+1:0]   py;
   logic        [bst_pkg::D2_BITS-1:0]       dist_sq_in;
   logic        [bst_pkg::D2_BITS-1:0]       dist_sq_ff;

   always_comb begin
      dx = $signed({1'b0, a_x}) - $signed({1'b0, b_x});
      dy = $signed({1'b0, a_y}) - $signed({1'b0, b_y});
      px = dx * dx;
      py = dy * dy;
      dist_sq_in = {1'b0, px[2*bst_pkg::UNIT_BITS-1:0]}
                 + {1'b0, py[2*bst_pkg::UNIT_BITS-1:0]};
   end

   always_ff @(posedge clock) begin
      dist_sq_ff <= dist_sq_in;
   end

   assign dist_sq = dist_sq_ff;

endmodule

/* design/brightest_spot_table.sv */
// Top level of the brightest spot table: control, table memory and result register.
//
// Usage. Items arrive on the req_ channel (valid/ready). Operation offer tests a
// candidate against the table, dump reads out every active slot, clear empties
// the table. Results leave on the rsp_ channel (valid/ready); rsp_last marks the
// final result of an item. Registers are written on the csr_ channel, which is
// always ready; the user must write them only while the block is idle, which
// the block itself does not enforce.
// Sequence. An offer passes ST_PREP0 to ST_PREP3 for setup, scans one slot per
// cycle through the shared squared distance unit, drains and decides. After a
// replacement each cleared neighbor is walked out, one slot per cycle while the
// output register is free. A dump reads each slot, then loads its result.
// Throughput. One item at a time; req_ready is high only between items, but a
// finished result may still wait in the output register while the next item is
// taken.
// Reset. The table reads empty at once (per-slot valid bits are cleared), the
// registers return to 4, 1 and 1, and no result is pending.
// Stall. A state that loads a result holds until the pending result is taken.
module brightest_spot_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [11:0] req_pos_x,
   input  logic [11:0] req_pos_y,
   input  logic [9:0]  req_plane,
   input  logic signed [23:0] req_strength,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_action,
   output logic [5:0]  rsp_slot,
   output logic [11:0] rsp_entry_x,
   output logic [11:0] rsp_entry_y,
   output logic [9:0]  rsp_entry_plane,
   output logic [22:0] rsp_entry_strength,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [bst_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [bst_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   bst_pkg::state_type                 state_ff, state_in;
   logic [bst_pkg::ACTIVE_BITS-1:0]    active_slots_ff, active_slots_in;
   logic [bst_pkg::NEAR_BITS-1:0]      near_ff, near_in;
   logic [bst_pkg::THRESH_BITS-1:0]    thr_ff, thr_in;
   bst_pkg::entry_type                 cand_ff, cand_in;
   bst_pkg::action_type                one_act_ff, one_act_in;
   logic [bst_pkg::SLOT_BITS-1:0]      walk_ff, walk_in;
   logic [bst_pkg::TABLE_SLOTS-1:0]    valid_ff, valid_in;
   logic [bst_pkg::NEAR_BITS-1:0]      nk_ff, nk_in;
   logic [bst_pkg::D2_BITS-1:0]        near2_ff, near2_in;
   logic [bst_pkg::D2_BITS-1:0]        full2_ff, full2_in;
   logic                               s1_v_ff, s1_v_in;
   logic [bst_pkg::SLOT_BITS-1:0]      s1_idx_ff, s1_idx_in;
   logic                               s2_v_ff, s2_v_in;
   logic [bst_pkg::SLOT_BITS-1:0]      s2_idx_ff, s2_idx_in;
   logic [bst_pkg::STRENGTH_BITS-1:0]  s2_str_ff, s2_str_in;
   logic                               dup_ff, dup_in;
   logic                               have_ff, have_in;
   logic [bst_pkg::SLOT_BITS-1:0]      best_ff, best_in;
   logic [bst_pkg::STRENGTH_BITS-1:0]  best_s_ff, best_s_in;
   logic                               empty_found_ff, empty_found_in;
   logic [bst_pkg::SLOT_BITS-1:0]      empty_idx_ff, empty_idx_in;
   logic                               min_seen_ff, min_seen_in;
   logic [bst_pkg::STRENGTH_BITS-1:0]  min_s_ff, min_s_in;
   logic [bst_pkg::SLOT_BITS-1:0]      min_idx_ff, min_idx_in;
   logic [bst_pkg::TABLE_SLOTS-1:0]    clr_mask_ff, clr_mask_in;
   logic [bst_pkg::COUNT_BITS-1:0]     clr_cnt_ff, clr_cnt_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   bst_pkg::action_type                rsp_action_ff, rsp_action_in;
   logic [5:0]                         rsp_slot_ff, rsp_slot_in;
   logic [11:0]                        rsp_x_ff, rsp_x_in;
   logic [11:0]                        rsp_y_ff, rsp_y_in;
   logic [9:0]                         rsp_plane_ff, rsp_plane_in;
   logic [22:0]                        rsp_str_ff, rsp_str_in;
   logic                               rsp_last_ff, rsp_last_in;

   bst_pkg::entry_type                 mem [bst_pkg::TABLE_SLOTS];
   bst_pkg::entry_type                 rd_data_ff;
   logic                               rd_valid_ff;
   bst_pkg::entry_type                 rd_entry;
   logic                               rd_en;
   logic                               we;
   logic [bst_pkg::SLOT_BITS-1:0]      wr_addr;

   logic [bst_pkg::UNIT_BITS-1:0]      unit_ax, unit_bx, unit_ay, unit_by;
   logic [bst_pkg::D2_BITS-1:0]        d2;

   logic [bst_pkg::COUNT_BITS-1:0]     slots_n;
   logic [bst_pkg::SLOT_BITS-1:0]      n_last;
   logic [bst_pkg::SCALED_BITS-1:0]    scaled;
   logic [bst_pkg::PROD_BITS-1:0]      prod;
   logic [bst_pkg::COUNT_BITS-1:0]     rep_cnt;
   logic                               out_free;
   logic                               load;
   bst_pkg::action_type                ld_act;
   logic [bst_pkg::SLOT_BITS-1:0]      ld_slot;
   bst_pkg::entry_type                 ld_entry;
   logic                               ld_last;

   assign req_ready = (state_ff == bst_pkg::ST_IDLE);
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rd_entry  = rd_valid_ff ? rd_data_ff : '0;

   always_comb begin
      if (active_slots_ff == '0) begin
         slots_n = bst_pkg::COUNT_BITS'(1);
      end else if (active_slots_ff > bst_pkg::ACTIVE_BITS'(bst_pkg::TABLE_SLOTS)) begin
         slots_n = bst_pkg::COUNT_BITS'(bst_pkg::TABLE_SLOTS);
      end else begin
         slots_n = bst_pkg::COUNT_BITS'(active_slots_ff);
      end
      n_last = bst_pkg::SLOT_BITS'(slots_n - bst_pkg::COUNT_BITS'(1));
      scaled = bst_pkg::SCALED_BITS'({near_ff, 2'b00}) + bst_pkg::SCALED_BITS'(near_ff);
      prod   = bst_pkg::PROD_BITS'(scaled) * bst_pkg::PROD_BITS'(bst_pkg::DIV6_MUL);
      rep_cnt = clr_cnt_ff - bst_pkg::COUNT_BITS'(clr_mask_ff[best_ff]);
   end

   bst_dist u_dist (
      .clock   (clock),
      .a_x     (unit_ax),
      .b_x     (unit_bx),
      .a_y     (unit_ay),
      .b_y     (unit_by),
      .dist_sq (d2)
   );

   always_comb begin
      state_in       = state_ff;
      active_slots_in = active_slots_ff;
      near_in        = near_ff;
      thr_in         = thr_ff;
      cand_in        = cand_ff;
      one_act_in     = one_act_ff;
      walk_in        = walk_ff;
      valid_in       = valid_ff;
      nk_in          = nk_ff;
      near2_in       = near2_ff;
      full2_in       = full2_ff;
      s1_v_in        = 1'b0;
      s1_idx_in      = walk_ff;
      s2_v_in        = s1_v_ff;
      s2_idx_in      = s1_idx_ff;
      s2_str_in      = rd_entry.strength;
      dup_in         = dup_ff;
      have_in        = have_ff;
      best_in        = best_ff;
      best_s_in      = best_s_ff;
      empty_found_in = empty_found_ff;
      empty_idx_in   = empty_idx_ff;
      min_seen_in    = min_seen_ff;
      min_s_in       = min_s_ff;
      min_idx_in     = min_idx_ff;
      clr_mask_in    = clr_mask_ff;
      clr_cnt_in     = clr_cnt_ff;
      rd_en          = 1'b0;
      we             = 1'b0;
      wr_addr        = best_ff;
      load           = 1'b0;
      ld_act         = bst_pkg::ACT_IGNORED;
      ld_slot        = '0;
      ld_entry       = '0;
      ld_last        = 1'b1;
      unit_ax        = bst_pkg::UNIT_BITS'(rd_entry.x);
      unit_bx        = bst_pkg::UNIT_BITS'(cand_ff.x);
      unit_ay        = bst_pkg::UNIT_BITS'(rd_entry.y);
      unit_by        = bst_pkg::UNIT_BITS'(cand_ff.y);

      if (csr_valid) begin
         unique case (bst_pkg::csr_type'(csr_index))
            bst_pkg::CSR_ACTIVE_SLOTS:  active_slots_in = csr_data[bst_pkg::ACTIVE_BITS-1:0];
            bst_pkg::CSR_NEAR_DISTANCE: near_in = csr_data[bst_pkg::NEAR_BITS-1:0];
            bst_pkg::CSR_THRESHOLD:     thr_in = csr_data[bst_pkg::THRESH_BITS-1:0];
            default: ;
         endcase
      end

      if (s2_v_ff) begin
         if (d2 < near2_ff) begin
            dup_in = 1'b1;
            if (cand_ff.strength > s2_str_ff && (!have_ff || s2_str_ff > best_s_ff)) begin
               have_in   = 1'b1;
               best_in   = s2_idx_ff;
               best_s_in = s2_str_ff;
            end
         end
         if (s2_str_ff == '0 && !empty_found_ff) begin
            empty_found_in = 1'b1;
            empty_idx_in   = s2_idx_ff;
         end
         if (!min_seen_ff || s2_str_ff < min_s_ff) begin
            min_seen_in = 1'b1;
            min_s_in    = s2_str_ff;
            min_idx_in  = s2_idx_ff;
         end
         if (d2 < full2_ff && s2_str_ff < cand_ff.strength) begin
            clr_mask_in[s2_idx_ff] = 1'b1;
            clr_cnt_in = clr_cnt_ff + bst_pkg::COUNT_BITS'(1);
         end
      end

      unique case (state_ff)
         bst_pkg::ST_IDLE: begin
            if (req_valid) begin
               cand_in.x        = bst_pkg::COORD_BITS'(req_pos_x);
               cand_in.y        = bst_pkg::COORD_BITS'(req_pos_y);
               cand_in.plane    = req_plane;
               cand_in.strength = req_strength[bst_pkg::STRENGTH_BITS-1:0];
               unique case (bst_pkg::op_type'(req_operation))
                  bst_pkg::OP_OFFER: begin
                     if (!req_strength[23] &&
                         req_strength[bst_pkg::STRENGTH_BITS-1:0] > thr_ff) begin
                        state_in = bst_pkg::ST_PREP0;
                     end else begin
                        one_act_in = bst_pkg::ACT_IGNORED;
                        state_in   = bst_pkg::ST_ONE;
                     end
                  end
                  bst_pkg::OP_DUMP: begin
                     walk_in  = '0;
                     state_in = bst_pkg::ST_DUMP_RD;
                  end
                  bst_pkg::OP_CLEAR: begin
                     valid_in   = '0;
                     one_act_in = bst_pkg::ACT_CLEARED;
                     state_in   = bst_pkg::ST_ONE;
                  end
                  default: begin
                     one_act_in = bst_pkg::ACT_IGNORED;
                     state_in   = bst_pkg::ST_ONE;
                  end
               endcase
            end
         end
         bst_pkg::ST_ONE: begin
            if (out_free) begin
               load     = 1'b1;
               ld_act   = one_act_ff;
               state_in = bst_pkg::ST_IDLE;
            end
         end
         bst_pkg::ST_PREP0: begin
            nk_in          = prod[bst_pkg::DIV6_SHIFT +: bst_pkg::NEAR_BITS];
            dup_in         = 1'b0;
            have_in        = 1'b0;
            best_in        = '0;
            best_s_in      = '0;
            empty_found_in = 1'b0;
            empty_idx_in   = '0;
            min_seen_in    = 1'b0;
            min_s_in       = '0;
            min_idx_in     = '0;
            clr_mask_in    = '0;
            clr_cnt_in     = '0;
            walk_in        = '0;
            state_in       = bst_pkg::ST_PREP1;
         end
         bst_pkg::ST_PREP1: begin
            unit_ax  = bst_pkg::UNIT_BITS'(nk_ff);
            unit_bx  = '0;
            unit_ay  = '0;
            unit_by  = '0;
            state_in = bst_pkg::ST_PREP2;
         end
         bst_pkg::ST_PREP2: begin
            near2_in = d2;
            unit_ax  = bst_pkg::UNIT_BITS'(near_ff);
            unit_bx  = '0;
            unit_ay  = '0;
            unit_by  = '0;
            state_in = bst_pkg::ST_PREP3;
         end
         bst_pkg::ST_PREP3: begin
            full2_in = d2;
            state_in = bst_pkg::ST_SCAN;
         end
         bst_pkg::ST_SCAN: begin
            rd_en   = 1'b1;
            s1_v_in = 1'b1;
            if (walk_ff == n_last) begin
               walk_in  = '0;
               state_in = bst_pkg::ST_DRAIN;
            end else begin
               walk_in = walk_ff + 1'b1;
            end
         end
         bst_pkg::ST_DRAIN: begin
            if (!s1_v_ff && !s2_v_ff) begin
               state_in = bst_pkg::ST_DECIDE;
            end
         end
         bst_pkg::ST_DECIDE: begin
            if (out_free) begin
               load     = 1'b1;
               state_in = bst_pkg::ST_IDLE;
               if (have_ff) begin
                  we                   = 1'b1;
                  wr_addr              = best_ff;
                  valid_in[best_ff]    = 1'b1;
                  ld_act               = bst_pkg::ACT_REPLACED;
                  ld_slot              = best_ff;
                  ld_entry             = cand_ff;
                  clr_mask_in[best_ff] = 1'b0;
                  clr_cnt_in           = rep_cnt;
                  walk_in              = '0;
                  ld_last              = (rep_cnt == '0);
                  if (rep_cnt != '0) begin
                     state_in = bst_pkg::ST_CLR;
                  end
               end else if (dup_ff) begin
                  ld_act = bst_pkg::ACT_REJECTED;
               end else if (empty_found_ff) begin
                  we                     = 1'b1;
                  wr_addr                = empty_idx_ff;
                  valid_in[empty_idx_ff] = 1'b1;
                  ld_act                 = bst_pkg::ACT_FILLED;
                  ld_slot                = empty_idx_ff;
                  ld_entry               = cand_ff;
               end else if (min_s_ff < cand_ff.strength) begin
                  we                   = 1'b1;
                  wr_addr              = min_idx_ff;
                  valid_in[min_idx_ff] = 1'b1;
                  ld_act               = bst_pkg::ACT_EVICTED;
                  ld_slot              = min_idx_ff;
                  ld_entry             = cand_ff;
               end else begin
                  ld_act = bst_pkg::ACT_REJECTED;
               end
            end
         end
         bst_pkg::ST_CLR: begin
            if (clr_mask_ff[walk_ff]) begin
               if (out_free) begin
                  load                 = 1'b1;
                  ld_act               = bst_pkg::ACT_CLEARED;
                  ld_slot              = walk_ff;
                  ld_last              = (clr_cnt_ff == bst_pkg::COUNT_BITS'(1));
                  valid_in[walk_ff]    = 1'b0;
                  clr_mask_in[walk_ff] = 1'b0;
                  clr_cnt_in           = clr_cnt_ff - bst_pkg::COUNT_BITS'(1);
                  walk_in              = walk_ff + 1'b1;
                  if (clr_cnt_ff == bst_pkg::COUNT_BITS'(1)) begin
                     state_in = bst_pkg::ST_IDLE;
                  end
               end
            end else begin
               walk_in = walk_ff + 1'b1;
            end
         end
         bst_pkg::ST_DUMP_RD: begin
            rd_en    = 1'b1;
            state_in = bst_pkg::ST_DUMP_EMIT;
         end
         bst_pkg::ST_DUMP_EMIT: begin
            if (out_free) begin
               load     = 1'b1;
               ld_act   = bst_pkg::ACT_DUMP;
               ld_slot  = walk_ff;
               ld_entry = rd_entry;
               ld_last  = (walk_ff == n_last);
               if (walk_ff == n_last) begin
                  walk_in  = '0;
                  state_in = bst_pkg::ST_IDLE;
               end else begin
                  walk_in  = walk_ff + 1'b1;
                  state_in = bst_pkg::ST_DUMP_RD;
               end
            end
         end
         default: begin
            state_in = bst_pkg::ST_IDLE;
         end
      endcase

      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_action_in = rsp_action_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_plane_in  = rsp_plane_ff;
      rsp_str_in    = rsp_str_ff;
      rsp_last_in   = rsp_last_ff;
      if (load) begin
         rsp_valid_in  = 1'b1;
         rsp_action_in = ld_act;
         rsp_slot_in   = 6'(ld_slot);
         rsp_x_in      = 12'(ld_entry.x);
         rsp_y_in      = 12'(ld_entry.y);
         rsp_plane_in  = ld_entry.plane;
         rsp_str_in    = ld_entry.strength;
         rsp_last_in   = ld_last;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wr_addr] <= cand_ff;
      end
      if (rd_en) begin
         rd_data_ff  <= mem[walk_ff];
         rd_valid_ff <= valid_ff[walk_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= bst_pkg::ST_IDLE;
         active_slots_ff <= bst_pkg::ACTIVE_BITS'(4);
         near_ff         <= bst_pkg::NEAR_BITS'(1);
         thr_ff          <= bst_pkg::THRESH_BITS'(1);
         walk_ff         <= '0;
         valid_ff        <= '0;
         s1_v_ff         <= 1'b0;
         s2_v_ff         <= 1'b0;
         clr_mask_ff     <= '0;
         clr_cnt_ff      <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         active_slots_ff <= active_slots_in;
         near_ff         <= near_in;
         thr_ff          <= thr_in;
         walk_ff         <= walk_in;
         valid_ff        <= valid_in;
         s1_v_ff         <= s1_v_in;
         s2_v_ff         <= s2_v_in;
         clr_mask_ff     <= clr_mask_in;
         clr_cnt_ff      <= clr_cnt_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff        <= cand_in;
      one_act_ff     <= one_act_in;
      nk_ff          <= nk_in;
      near2_ff       <= near2_in;
      full2_ff       <= full2_in;
      s1_idx_ff      <= s1_idx_in;
      s2_idx_ff      <= s2_idx_in;
      s2_str_ff      <= s2_str_in;
      dup_ff         <= dup_in;
      have_ff        <= have_in;
      best_ff        <= best_in;
      best_s_ff      <= best_s_in;
      empty_found_ff <= empty_found_in;
      empty_idx_ff   <= empty_idx_in;
      min_seen_ff    <= min_seen_in;
      min_s_ff       <= min_s_in;
      min_idx_ff     <= min_idx_in;
      rsp_action_ff  <= rsp_action_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_x_ff       <= rsp_x_in;
      rsp_y_ff       <= rsp_y_in;
      rsp_plane_ff   <= rsp_plane_in;
      rsp_str_ff     <= rsp_str_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_action         = rsp_action_ff;
   assign rsp_slot           = rsp_slot_ff;
   assign rsp_entry_x        = rsp_x_ff;
   assign rsp_entry_y        = rsp_y_ff;
   assign rsp_entry_plane    = rsp_plane_ff;
   assign rsp_entry_strength = rsp_str_ff;
   assign rsp_last           = rsp_last_ff;

   a_load_into_free: assert property (@(posedge clock) disable iff (reset)
      load |-> (!rsp_valid_ff || rsp_ready))
      else $error("A result was loaded over one that was not yet transferred.");

   a_clear_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bst_pkg::ST_CLR) |-> ($countones(clr_mask_ff) == clr_cnt_ff))
      else $error("Pending clear count disagrees with the clear mask.");

   a_scan_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bst_pkg::ST_DECIDE) |-> (!s1_v_ff && !s2_v_ff))
      else $error("Decision taken while the scan pipeline still held slots.");

   a_replace_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bst_pkg::ST_DECIDE && load && have_ff) |=> valid_ff[$past(best_ff)])
      else $error("Replaced slot is not marked valid.");

endmodule

/* dv/brightest_spot_table_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the brightest spot table, with its own table predictor.
module brightest_spot_table_tb;

   localparam int CLOCK_HALF_NS = 10;
   localparam int RESET_CYCLES  = 10;
   localparam int SETTLE_CYCLES = 4;
   localparam int END_CYCLES    = 300;
   localparam int TIMEOUT_NS    = 20_000_000;
   localparam int RANDOM_ITEMS  = 38;
   localparam int STRENGTH_MAX  = 4718592;
   localparam int COORD_MAX     = (1 << bst_pkg::COORD_BITS) - 1;
   localparam int PLANE_MAX     = (1 << bst_pkg::PLANE_BITS) - 1;
   localparam int NEAR_MAX      = (1 << bst_pkg::NEAR_BITS) - 1;
   localparam int ACTIVE_MAX    = (1 << bst_pkg::ACTIVE_BITS) - 1;
   localparam int DATA_ONES     = (1 << bst_pkg::CSR_DATA_BITS) - 1;
   localparam logic [bst_pkg::CSR_INDEX_BITS-1:0] CSR_UNUSED = 2'd3;

   typedef struct {
      bst_pkg::action_type           action;
      logic [bst_pkg::SLOT_BITS-1:0] slot;
      bst_pkg::entry_type            entry;
      logic                          last;
   } spot_result_type;

   logic                               clock;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_ready;
   logic [1:0]                         req_operation = '0;
   logic [11:0]                        req_pos_x = '0;
   logic [11:0]                        req_pos_y = '0;
   logic [9:0]                         req_plane = '0;
   logic signed [23:0]                 req_strength = '0;
   logic                               rsp_valid;
   logic                               rsp_ready = 1'b0;
   logic [2:0]                         rsp_action;
   logic [5:0]                         rsp_slot;
   logic [11:0]                        rsp_entry_x;
   logic [11:0]                        rsp_entry_y;
   logic [9:0]                         rsp_entry_plane;
   logic [22:0]                        rsp_entry_strength;
   logic                               rsp_last;
   logic                               csr_valid = 1'b0;
   logic                               csr_ready;
   logic [bst_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [bst_pkg::CSR_DATA_BITS-1:0]  csr_data = '0;

   bst_pkg::entry_type                 spot_model [bst_pkg::TABLE_SLOTS];
   logic [bst_pkg::ACTIVE_BITS-1:0]    model_active = 7'd4;
   logic [bst_pkg::NEAR_BITS-1:0]      model_near = 12'd1;
   logic [bst_pkg::THRESH_BITS-1:0]    model_thresh = 23'd1;
   spot_result_type                    expected_results [$];
   int                                 errors = 0;
   int                                 send_idle_pct = 0;
   int                                 stall_pct = 0;

   brightest_spot_table u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_pos_x          (req_pos_x),
      .req_pos_y          (req_pos_y),
      .req_plane          (req_plane),
      .req_strength       (req_strength),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_action         (rsp_action),
      .rsp_slot           (rsp_slot),
      .rsp_entry_x        (rsp_entry_x),
      .rsp_entry_y        (rsp_entry_y),
      .rsp_entry_plane    (rsp_entry_plane),
      .rsp_entry_strength (rsp_entry_strength),
      .rsp_last           (rsp_last),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF_NS clock = ~clock;
   end

   initial begin
      #TIMEOUT_NS;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic spot_result_type make_result(bst_pkg::action_type act, int slot,
         bst_pkg::entry_type e);
      spot_result_type r;
      r.action = act;
      r.slot   = slot[bst_pkg::SLOT_BITS-1:0];
      r.entry  = e;
      r.last   = 1'b0;
      return r;
   endfunction

   function automatic int dist_sq(bst_pkg::entry_type e, logic [bst_pkg::COORD_BITS-1:0] x,
         logic [bst_pkg::COORD_BITS-1:0] y);
      int dx;
      int dy;
      dx = int'(e.x) - int'(x);
      dy = int'(e.y) - int'(y);
      return dx * dx + dy * dy;
   endfunction

   function automatic void predict_item(bst_pkg::op_type op,
         logic [bst_pkg::COORD_BITS-1:0] x, logic [bst_pkg::COORD_BITS-1:0] y,
         logic [bst_pkg::PLANE_BITS-1:0] p, logic signed [23:0] s);
      spot_result_type    outs [$];
      bst_pkg::entry_type none;
      bst_pkg::entry_type cand;
      int                 n;
      int                 q;
      int                 best;
      int                 cho;
      int                 nk;
      int                 near2;
      int                 full2;
      int unsigned        least;
      bit                 dup;
      bit                 have;
      bit                 filled;
      none   = '0;
      dup    = 1'b0;
      have   = 1'b0;
      filled = 1'b0;
      best   = 0;
      cho    = 0;
      n = (model_active == 0) ? 1 :
          (model_active > bst_pkg::TABLE_SLOTS) ? bst_pkg::TABLE_SLOTS : int'(model_active);
      case (op)
         bst_pkg::OP_DUMP: begin
            for (q = 0; q < n; q++) begin
               outs.push_back(make_result(bst_pkg::ACT_DUMP, q, spot_model[q]));
            end
         end
         bst_pkg::OP_CLEAR: begin
            for (q = 0; q < bst_pkg::TABLE_SLOTS; q++) spot_model[q] = none;
            outs.push_back(make_result(bst_pkg::ACT_CLEARED, 0, none));
         end
         bst_pkg::OP_OFFER: begin
            if (int'(s) <= int'(model_thresh)) begin
               outs.push_back(make_result(bst_pkg::ACT_IGNORED, 0, none));
            end else begin
               cand.x        = x;
               cand.y        = y;
               cand.plane    = p;
               cand.strength = s[bst_pkg::STRENGTH_BITS-1:0];
               nk    = (int'(model_near) * 5) / 6;
               near2 = nk * nk;
               full2 = int'(model_near) * int'(model_near);
               for (q = 0; q < n; q++) begin
                  if (dist_sq(spot_model[q], x, y) < near2) begin
                     if (cand.strength > spot_model[q].strength &&
                         (!have || spot_model[q].strength > spot_model[best].strength)) begin
                        best = q;
                        have = 1'b1;
                     end
                     dup = 1'b1;
                  end
               end
               if (have) begin
                  spot_model[best] = cand;
                  outs.push_back(make_result(bst_pkg::ACT_REPLACED, best, cand));
                  for (q = 0; q < n; q++) begin
                     if (q != best && dist_sq(spot_model[q], x, y) < full2 &&
                         spot_model[q].strength < cand.strength) begin
                        spot_model[q] = none;
                        outs.push_back(make_result(bst_pkg::ACT_CLEARED, q, none));
                     end
                  end
               end else if (dup) begin
                  outs.push_back(make_result(bst_pkg::ACT_REJECTED, 0, none));
               end else begin
                  for (q = 0; q < n && !filled; q++) begin
                     if (spot_model[q].strength == 0) begin
                        spot_model[q] = cand;
                        outs.push_back(make_result(bst_pkg::ACT_FILLED, q, cand));
                        filled = 1'b1;
                     end
                  end
                  if (!filled) begin
                     least = 1 << 30;
                     for (q = 0; q < n; q++) begin
                        if (spot_model[q].strength < least) begin
                           least = spot_model[q].strength;
                           cho   = q;
                        end
                     end
                     if (least < cand.strength) begin
                        spot_model[cho] = cand;
                        outs.push_back(make_result(bst_pkg::ACT_EVICTED, cho, cand));
                     end else begin
                        outs.push_back(make_result(bst_pkg::ACT_REJECTED, 0, none));
                     end
                  end
               end
            end
         end
         default: begin
            outs.push_back(make_result(bst_pkg::ACT_IGNORED, 0, none));
         end
      endcase
      outs[outs.size() - 1].last = 1'b1;
      foreach (outs[i]) expected_results.push_back(outs[i]);
   endfunction

   function automatic void apply_register(logic [bst_pkg::CSR_INDEX_BITS-1:0] index,
         logic [bst_pkg::CSR_DATA_BITS-1:0] data);
      case (index)
         bst_pkg::CSR_ACTIVE_SLOTS: begin
            model_active = data[bst_pkg::ACTIVE_BITS-1:0];
         end
         bst_pkg::CSR_NEAR_DISTANCE: begin
            model_near = data[bst_pkg::NEAR_BITS-1:0];
         end
         bst_pkg::CSR_THRESHOLD: begin
            model_thresh = data[bst_pkg::THRESH_BITS-1:0];
         end
         default: begin
         end
      endcase
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endfunction

   function automatic void check_result();
      spot_result_type want;
      if (expected_results.size() == 0) begin
         errors++;
         $display("%0t: unexpected result transfer, action %0d slot %0d strength %0d",
                  $time, rsp_action, rsp_slot, rsp_entry_strength);
      end else begin
         want = expected_results.pop_front();
         check_field("action", want.action, rsp_action);
         check_field("slot", want.slot, rsp_slot);
         check_field("entry_x", want.entry.x, rsp_entry_x);
         check_field("entry_y", want.entry.y, rsp_entry_y);
         check_field("entry_plane", want.entry.plane, rsp_entry_plane);
         check_field("entry_strength", want.entry.strength, rsp_entry_strength);
         check_field("last", want.last, rsp_last);
      end
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) check_result();
         if (req_valid && req_ready) begin
            predict_item(bst_pkg::op_type'(req_operation), req_pos_x, req_pos_y, req_plane,
                         req_strength);
         end
         if (csr_valid && csr_ready) apply_register(csr_index, csr_data);
      end
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic send_item(bst_pkg::op_type op, int x, int y, int p, int s);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_pos_x     <= x[bst_pkg::COORD_BITS-1:0];
      req_pos_y     <= y[bst_pkg::COORD_BITS-1:0];
      req_plane     <= p[bst_pkg::PLANE_BITS-1:0];
      req_strength  <= s[23:0];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_transfer(logic [bst_pkg::CSR_INDEX_BITS-1:0] index, int data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data[bst_pkg::CSR_DATA_BITS-1:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic configure(int active, int near, int thresh);
      wait_for_drain();
      csr_transfer(bst_pkg::CSR_ACTIVE_SLOTS, active);
      csr_transfer(bst_pkg::CSR_NEAR_DISTANCE, near);
      csr_transfer(bst_pkg::CSR_THRESHOLD, thresh);
      csr_valid <= 1'b0;
   endtask

   task automatic test_reset_values();
      send_item(bst_pkg::OP_DUMP, 0, 0, 0, 0);
      send_item(bst_pkg::OP_OFFER, 0, 0, 0, 1);
      send_item(bst_pkg::OP_OFFER, COORD_MAX, COORD_MAX, PLANE_MAX, 2);
      send_item(bst_pkg::OP_NONE, COORD_MAX, COORD_MAX, PLANE_MAX, -1);
   endtask

   task automatic test_fill_evict_reject();
      configure(3, 10, 100);
      send_item(bst_pkg::OP_CLEAR, COORD_MAX, 0, PLANE_MAX, STRENGTH_MAX);
      send_item(bst_pkg::OP_OFFER, 1000, 1000, 5, 500);
      send_item(bst_pkg::OP_OFFER, 2000, 2000, 6, 300);
      send_item(bst_pkg::OP_OFFER, 3000, 3000, 7, 400);
      send_item(bst_pkg::OP_OFFER, 500, 3000, 8, 350);
      send_item(bst_pkg::OP_OFFER, 3000, 500, 9, 200);
      send_item(bst_pkg::OP_OFFER, 1003, 1000, 10, 400);
      send_item(bst_pkg::OP_OFFER, 1000, 1000, 11, 100);
      send_item(bst_pkg::OP_OFFER, 1000, 1000, 12, -STRENGTH_MAX);
   endtask

   // The last offer lands next to the empty slots at the origin, so it takes over
   // an empty slot and clears every other empty slot within range.
   task automatic test_replace_neighbors();
      configure(8, 60, 1);
      send_item(bst_pkg::OP_CLEAR, 0, 0, 0, 0);
      send_item(bst_pkg::OP_OFFER, 200, 200, 1, 5);
      send_item(bst_pkg::OP_OFFER, 200, 255, 2, 5);
      send_item(bst_pkg::OP_OFFER, 200, 201, 3, 50);
      send_item(bst_pkg::OP_OFFER, 10, 10, PLANE_MAX, STRENGTH_MAX);
      send_item(bst_pkg::OP_DUMP, 0, 0, 0, 0);
   endtask

   task automatic test_register_extremes();
      configure(0, NEAR_MAX, 0);
      send_item(bst_pkg::OP_CLEAR, 0, 0, 0, 0);
      send_item(bst_pkg::OP_OFFER, COORD_MAX, 0, 0, 1);
      send_item(bst_pkg::OP_OFFER, 0, COORD_MAX, PLANE_MAX, 2);
      send_item(bst_pkg::OP_DUMP, 0, 0, 0, 0);
      wait_for_drain();
      csr_transfer(CSR_UNUSED, DATA_ONES);
      csr_transfer(bst_pkg::CSR_ACTIVE_SLOTS, ACTIVE_MAX);
      csr_transfer(bst_pkg::CSR_THRESHOLD, DATA_ONES);
      csr_valid <= 1'b0;
      send_item(bst_pkg::OP_OFFER, 1, 1, 1, STRENGTH_MAX);
      send_item(bst_pkg::OP_DUMP, 0, 0, 0, 0);
      configure(bst_pkg::TABLE_SLOTS, 1, STRENGTH_MAX - 1);
      send_item(bst_pkg::OP_OFFER, 2, 2, 2, STRENGTH_MAX);
      send_item(bst_pkg::OP_OFFER, 3, 3, 3, STRENGTH_MAX - 1);
   endtask

   // Most offers fall in a window a few near distances wide around the origin,
   // so that replacements, neighbor clears and evictions come up often.
   task automatic send_random_item();
      int pick;
      int span;
      int x;
      int y;
      int p;
      int s;
      pick = $urandom_range(99);
      span = 3 * int'(model_near);
      if (span > COORD_MAX) span = COORD_MAX;
      x = $urandom_range(COORD_MAX);
      y = $urandom_range(COORD_MAX);
      p = $urandom_range(PLANE_MAX);
      s = int'($urandom_range(2 * STRENGTH_MAX)) - STRENGTH_MAX;
      if (pick < 6) begin
         send_item(bst_pkg::OP_DUMP, x, y, p, s);
      end else if (pick < 9) begin
         send_item(bst_pkg::OP_CLEAR, x, y, p, s);
      end else if (pick < 12) begin
         send_item(bst_pkg::OP_NONE, x, y, p, s);
      end else if (pick < 30) begin
         send_item(bst_pkg::OP_OFFER, x, y, p, s);
      end else begin
         x = $urandom_range(span);
         y = $urandom_range(span);
         if ($urandom_range(9) == 0) begin
            s = int'(model_thresh) - int'($urandom_range(3));
         end else begin
            s = int'(model_thresh) + 1 + int'($urandom_range(4000));
         end
         if (s > STRENGTH_MAX) s = STRENGTH_MAX;
         send_item(bst_pkg::OP_OFFER, x, y, p, s);
      end
   endtask

   task automatic test_random_traffic(int idle, int stall, int active, int near, int thresh);
      configure(active, near, thresh);
      send_idle_pct = idle;
      stall_pct     = stall;
      repeat (RANDOM_ITEMS) send_random_item();
   endtask

   initial begin
      foreach (spot_model[i]) spot_model[i] = '0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_reset_values();
      test_fill_evict_reject();
      test_replace_neighbors();
      test_register_extremes();
      test_random_traffic(0, 0, 6, 40, 100);
      test_random_traffic(69, 0, 16, 300, 1);
      test_random_traffic(0, 69, bst_pkg::TABLE_SLOTS, NEAR_MAX, 1000);
      test_random_traffic(29, 29, 3, 700, 20000);
      wait_for_drain();
      repeat (END_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

/* sim.f */
design/bst_pkg.sv
design/bst_dist.sv
design/brightest_spot_table.sv
dv/brightest_spot_table_tb.sv
